FILE: src/vdi_pkg.sv
// Package with the constants and helpers of the vertex deduplication indexer.
package vdi_pkg;
	localparam int unsigned Capacity = 1024;
	localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
	localparam int unsigned CountW = $clog2(Capacity + 1);
	localparam int unsigned CoordW = 32;
	localparam int unsigned IndexW = 10;
	localparam int unsigned VtxW = 3 * CoordW;

	// Minus zero compares equal to plus zero.
	function automatic logic [CoordW-1:0] canon(input logic [CoordW-1:0] bits);
		logic [CoordW-1:0] r;
		r = (bits == {1'b1, {(CoordW-1){1'b0}}}) ? '0 : bits;
		return r;
	endfunction

	function automatic logic [VtxW-1:0] canon_vtx(input logic [VtxW-1:0] v);
		logic [VtxW-1:0] r;
		r = {canon(v[3*CoordW-1:2*CoordW]), canon(v[2*CoordW-1:CoordW]), canon(v[CoordW-1:0])};
		return r;
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_LAST = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;
endpackage

FILE: src/vertex_dedup_indexer_unit.sv
// Top level of the vertex deduplication indexer: scans a vertex memory for a match.
//
// Usage: one request on the input channel (coord_x, coord_y, coord_z) carries one
// vertex; one result (vertex_index, is_new, table_full) follows on the output channel.
// The stored vertices sit in a synchronous memory with a read and a write port that is scanned
// one entry per cycle from index zero up to the fill count. A request makes one read per
// stored entry through the memory port, plus issue, compare and result steps. A new vertex
// is written at the fill position when the scan finds no match, the table is not full and
// the result register is free. One request is handled at a time; in_ready is low while a
// scan is running. The result is held in an output register; a new request is taken while
// it waits. When the receiver stalls, the result register holds and the next result waits
// for it. Reset clears the fill count and the control state, not the memory; the memory
// contents are never compared beyond the fill count, so no clearing pass is needed. Reset
// empties the table at once.
module vertex_dedup_indexer_unit import vdi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CoordW-1:0] coord_x,
	input  logic [CoordW-1:0] coord_y,
	input  logic [CoordW-1:0] coord_z,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IndexW-1:0] vertex_index,
	output logic              is_new,
	output logic              table_full
);
	logic [VtxW-1:0]   mem [Capacity];
	logic [VtxW-1:0]   rd_q;
	logic [VtxW-1:0]   key_q;
	logic [VtxW-1:0]   raw_q;
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] ptr_q;
	logic [CountW-1:0] cmp_idx_q;
	logic              cmp_vld_q;
	logic              found_q;
	logic [CountW-1:0] found_idx_q;
	state_t            state_q;
	logic              res_vld_q;
	logic [IndexW-1:0] res_idx_q;
	logic              res_new_q;
	logic              res_full_q;
	logic              hit;
	logic              out_free;
	logic              wr_en;

	assign out_free = !res_vld_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign hit = cmp_vld_q && (canon_vtx(rd_q) == key_q);
	assign wr_en = (state_q == ST_OUT) && out_free && !found_q && (count_q < CountW'(Capacity));

	// Memory: one read per cycle during the scan, one write at the end.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AddrW-1:0]] <= raw_q;
		end
		rd_q <= mem[ptr_q[AddrW-1:0]];
	end

	// Request capture and compare pipeline payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_q <= {coord_x, coord_y, coord_z};
			key_q <= canon_vtx({coord_x, coord_y, coord_z});
		end
		cmp_idx_q <= ptr_q;
		if (hit && !found_q) begin
			found_idx_q <= cmp_idx_q;
		end
	end

	// Scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ptr_q     <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
			count_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmp_vld_q <= 1'b0;
					if (in_valid) begin
						found_q <= 1'b0;
						ptr_q   <= '0;
						state_q <= (count_q == '0) ? ST_LAST : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Issue a read of entry ptr_q; its data is compared next cycle.
					if (hit) begin
						found_q <= 1'b1;
					end
					cmp_vld_q <= 1'b1;
					ptr_q     <= ptr_q + 1'b1;
					if (ptr_q + 1'b1 >= count_q) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					cmp_vld_q <= 1'b0;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (wr_en) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			res_vld_q <= 1'b1;
		end else if (out_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			if (found_q) begin
				res_idx_q  <= found_idx_q[IndexW-1:0];
				res_new_q  <= 1'b0;
				res_full_q <= 1'b0;
			end else if (wr_en) begin
				res_idx_q  <= count_q[IndexW-1:0];
				res_new_q  <= 1'b1;
				res_full_q <= 1'b0;
			end else begin
				res_idx_q  <= '0;
				res_new_q  <= 1'b0;
				res_full_q <= 1'b1;
			end
		end
	end

	assign out_valid    = res_vld_q;
	assign vertex_index = res_idx_q;
	assign is_new       = res_new_q;
	assign table_full   = res_full_q;

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(Capacity)) else $error("fill count above capacity");
	// A new vertex and a full table are never flagged together.
	a_new_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_new && table_full)) else $error("new and full together");
	// The fill count moves only by a write.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(count_q)) else $error("fill count moved without write");
	// No request is taken while a scan runs.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("accept during scan");
endmodule
